[src/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define TSSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define TSSD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/tssd_pkg.sv]
// types and constants of the threshold step sequence detector
package tssd_pkg;

    localparam int MAX_STEPS   = 4;
    localparam int NUM_WORDS   = 4;
    localparam int WORD_IDX_W  = $clog2(NUM_WORDS);
    localparam int STEP_W      = 3;
    localparam int SAMPLE_W    = 16;
    localparam int SOURCE_W    = 8;
    localparam int WORD_W      = 35;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 35;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_TICK   = 2'd1,
        MODE_START  = 2'd2,
        MODE_STOP   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        RULE_NONE    = 2'd0,
        RULE_BELOW   = 2'd1,
        RULE_ABOVE   = 2'd2,
        RULE_TIMEOUT = 2'd3
    } rule_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_COUNT    = 3'd0,
        REG_SIGNAL_SELECT = 3'd1,
        REG_STEP_WORD_0   = 3'd2,
        REG_STEP_WORD_1   = 3'd3,
        REG_STEP_WORD_2   = 3'd4,
        REG_STEP_WORD_3   = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [STEP_W-1:0]                   step_count;
        logic [SOURCE_W-1:0]                 signal_select;
        logic [NUM_WORDS-1:0][WORD_W-1:0]    step_word;
    } cfg_t;

    typedef struct packed {
        logic in_full;
        logic out_full;
    } core_status_t;

endpackage

[src/tssd_channels.sv]
// valid/ready channel interfaces for items, results and configuration writes
interface tssd_in_if import tssd_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [1:0]                 mode;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [SOURCE_W-1:0]        sample_source;

    modport source (output valid, output mode, output sample_value, output sample_source,
                    input ready);
    modport sink (input valid, input mode, input sample_value, input sample_source,
                  output ready);
endinterface

interface tssd_out_if import tssd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              completed;
    logic [STEP_W-1:0] step_now;
    logic              active;

    modport source (output valid, output completed, output step_now, output active,
                    input ready);
    modport sink (input valid, input completed, input step_now, input active,
                  output ready);
endinterface

interface tssd_cfg_if import tssd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[src/tssd_cfg_regs.sv]
// configuration register file
module tssd_cfg_regs import tssd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    tssd_cfg_if.sink   cfg,
    output cfg_t       cfg_q
);

    logic [STEP_W-1:0]                step_count_reg;
    logic [SOURCE_W-1:0]              signal_select_reg;
    logic [NUM_WORDS-1:0][WORD_W-1:0] step_word_reg;
    logic                             wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg    <= STEP_W'(1);
            signal_select_reg <= '0;
            step_word_reg     <= '0;
        end
        else if (wr_en)
        begin
            // writes beyond the register list are dropped
            unique case (cfg.index)
                REG_STEP_COUNT:    step_count_reg    <= cfg.data[STEP_W-1:0];
                REG_SIGNAL_SELECT: signal_select_reg <= cfg.data[SOURCE_W-1:0];
                REG_STEP_WORD_0:   step_word_reg[0]  <= cfg.data[WORD_W-1:0];
                REG_STEP_WORD_1:   step_word_reg[1]  <= cfg.data[WORD_W-1:0];
                REG_STEP_WORD_2:   step_word_reg[2]  <= cfg.data[WORD_W-1:0];
                REG_STEP_WORD_3:   step_word_reg[3]  <= cfg.data[WORD_W-1:0];
                default:           ;
            endcase
        end
    end

    assign cfg_q.step_count    = step_count_reg;
    assign cfg_q.signal_select = signal_select_reg;
    assign cfg_q.step_word     = step_word_reg;

endmodule

[src/tssd_core.sv]
// input register, step evaluation, sequence state and result register
module tssd_core import tssd_pkg::*; #(
    parameter int STEP_LIMIT = MAX_STEPS
) (
    input  logic          clk,
    input  logic          rst_n,
    tssd_in_if.sink       samples,
    tssd_out_if.source    results,
    input  cfg_t          cfg_q,
    output core_status_t  status
);

    // input stage
    logic                       in_valid_reg;
    mode_t                      mode_reg;
    logic signed [SAMPLE_W-1:0] value_reg;
    logic [SOURCE_W-1:0]        source_reg;

    // sequence state
    logic                       running_reg,   running_next;
    logic [STEP_W-1:0]          step_pos_reg,  step_pos_next;
    logic [SAMPLE_W-1:0]        elapsed_reg,   elapsed_next;

    // result stage
    logic                       out_valid_reg;
    logic                       completed_reg, completed_next;
    logic [STEP_W-1:0]          step_now_reg;
    logic                       active_reg;

    logic                       in_xfer;
    logic                       advance;

    logic [STEP_W-1:0]          steps_used;
    logic [WORD_W-1:0]          word;
    logic signed [SAMPLE_W-1:0] thr;
    logic signed [SAMPLE_W-1:0] rval;
    logic signed [SAMPLE_W:0]   rval_ext;
    logic signed [SAMPLE_W:0]   elapsed_ext;
    rule_t                      rule;
    logic                       pass;
    logic                       rule_fires;
    logic [STEP_W-1:0]          step_inc;

    assign advance       = in_valid_reg && (!out_valid_reg || results.ready);
    assign samples.ready = !in_valid_reg || advance;
    assign in_xfer       = samples.valid && samples.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mode_reg   <= mode_t'(samples.mode);
            value_reg  <= samples.sample_value;
            source_reg <= samples.sample_source;
        end
    end

    // step table lookup, positions past the stored words read as zero
    assign steps_used = (cfg_q.step_count > STEP_W'(STEP_LIMIT)) ? STEP_W'(STEP_LIMIT)
                                                                 : cfg_q.step_count;
    assign word       = (step_pos_reg < STEP_W'(NUM_WORDS))
                        ? cfg_q.step_word[step_pos_reg[WORD_IDX_W-1:0]] : '0;
    assign thr        = word[15:0];
    assign rval       = word[31:16];
    assign rule       = rule_t'(word[34:33]);
    assign rval_ext   = {rval[SAMPLE_W-1], rval};
    assign elapsed_ext = $signed({1'b0, elapsed_reg});
    assign step_inc   = step_pos_reg + STEP_W'(1);

    assign pass = word[32] ? (value_reg < thr) : (value_reg > thr);

    always_comb
    begin
        case (rule)
            RULE_BELOW:   rule_fires = value_reg < rval;
            RULE_ABOVE:   rule_fires = value_reg > rval;
            RULE_TIMEOUT: rule_fires = elapsed_ext > rval_ext;
            default:      rule_fires = 1'b0;
        endcase
    end

    always_comb
    begin
        running_next   = running_reg;
        step_pos_next  = step_pos_reg;
        elapsed_next   = elapsed_reg;
        completed_next = 1'b0;
        unique case (mode_reg)
            MODE_SAMPLE:
            begin
                if (running_reg && source_reg == cfg_q.signal_select &&
                    step_pos_reg < steps_used)
                begin
                    if (pass)
                    begin
                        if (step_pos_reg == '0)
                        begin
                            elapsed_next = '0;
                        end
                        step_pos_next  = step_inc;
                        completed_next = step_inc >= steps_used;
                    end
                    else if (rule_fires)
                    begin
                        step_pos_next = '0;
                        elapsed_next  = '0;
                    end
                end
            end
            MODE_TICK:
            begin
                // saturating millisecond count
                if (elapsed_reg != '1)
                begin
                    elapsed_next = elapsed_reg + SAMPLE_W'(1);
                end
            end
            MODE_START:
            begin
                running_next  = 1'b1;
                step_pos_next = '0;
                elapsed_next  = '0;
            end
            MODE_STOP:
            begin
                running_next = 1'b0;
            end
            default:
            begin
                running_next = running_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= 1'b0;
            step_pos_reg  <= '0;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                running_reg   <= running_next;
                step_pos_reg  <= step_pos_next;
                elapsed_reg   <= elapsed_next;
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            completed_reg <= completed_next;
            step_now_reg  <= step_pos_next;
            active_reg    <= running_next;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.completed = completed_reg;
    assign results.step_now  = step_now_reg;
    assign results.active    = active_reg;

    assign status.in_full  = in_valid_reg;
    assign status.out_full = out_valid_reg;

endmodule

[src/threshold_step_sequence_detector.sv]
// top level of the threshold step sequence detector
// an input transfer fills the input register; its evaluation then fills the result register
// throughput: one item per cycle unless stalled; evaluation is one step-table read and two compares
// with both registers full, a held result stalls the input until that result transfers
// reset clears running, step position, elapsed ticks and both stage valids at once
// configuration resets to step count 1, signal 0 and all-zero step words
`include "assert_macros.svh"

module threshold_step_sequence_detector import tssd_pkg::*; #(
    parameter int STEP_LIMIT = MAX_STEPS
) (
    input  logic        clk,
    input  logic        rst_n,
    tssd_in_if.sink     samples,
    tssd_out_if.source  results,
    tssd_cfg_if.sink    cfg
);

    cfg_t         cfg_q;
    core_status_t status;

    tssd_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    tssd_core #(
        .STEP_LIMIT (STEP_LIMIT)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .results (results),
        .cfg_q   (cfg_q),
        .status  (status)
    );

    // a stalled result with a full input stage must hold off the source
    `TSSD_ASSERT(a_stall_backpressure,
        (results.valid && !results.ready && status.in_full) |-> !samples.ready,
        "input accepted while both stages are blocked")

    // completion always leaves a nonzero step position within the step limit
    `TSSD_ASSERT(a_completed_step,
        (results.valid && results.completed) |->
            (results.step_now != '0 && results.step_now <= STEP_W'(STEP_LIMIT)),
        "completion reported with an impossible step position")

    // an input transfer always fills the input stage on the next edge
    `TSSD_ASSERT(a_input_capture,
        (samples.valid && samples.ready) |=> status.in_full,
        "input transfer lost before evaluation")

    // the result stage valid mirrors the output port during and after reset
    `TSSD_ASSERT_ALWAYS(a_out_mirror,
        status.out_full == results.valid,
        "result stage and output valid disagree")

endmodule
